FILE: sv/imt_pkg.sv
// imt_pkg: shared constants and sequencer state type for the interval map table
// no dependencies
package imt_pkg;

	localparam int ENTRIES_DEF     = 64;
	localparam int KEY_WIDTH_DEF   = 32;
	localparam int VALUE_WIDTH_DEF = 8;

	localparam logic CMD_ASSIGN = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_INS_L,
		ST_INS_R,
		ST_RESP
	} imt_state_t;

endpackage

FILE: sv/imt_ram.sv
// imt_ram: generic single write port ram with registered read
// no dependencies
module imt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: sv/interval_map_table_unit.sv
// interval_map_table_unit: breakpoint table with range assign and key lookup
// depends on imt_pkg and imt_ram
//
// usage: one input word per command. command 0 assigns new_value over
// [range_begin, range_end), command 1 returns the value at probe_key.
// every input word gives exactly one output word on the out channel.
// in_ready is high only when the unit is idle; one word is worked at a time.
// a lookup makes one scan of the stored breakpoints in the ram, one entry
// read per cycle through the registered ram read, and then decides.
// an assign scans the same way, then shifts the tail, the entries above the
// range, when their place changes: each shift is a ram read then a ram write
// on the single port pair. last it writes the new left and right breakpoints
// where needed. an overflowing assign answers after the scan and decision,
// with no shift and no write.
// an empty range answers in the cycle after it is taken, with range_empty set.
// the result is held in the output register until out_ready; no new word is
// taken while it waits, and the unit is ready again in the cycle after the
// result is taken.
// reset empties the table and clears initial_value to zero; ram contents
// are not cleared, only entries below the count are ever read.
// cfg_we writes initial_value; the user must write it only while the unit is idle, the unit does not enforce this.
module interval_map_table_unit #(
	parameter int ENTRIES     = imt_pkg::ENTRIES_DEF,
	parameter int KEY_WIDTH   = imt_pkg::KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = imt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [VALUE_WIDTH-1:0] cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   command,
	input  logic [KEY_WIDTH-1:0]   range_begin,
	input  logic [KEY_WIDTH-1:0]   range_end,
	input  logic [VALUE_WIDTH-1:0] new_value,
	input  logic [KEY_WIDTH-1:0]   probe_key,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH-1:0] mapped_value,
	output logic                   range_empty,
	output logic                   table_overflow
);
	import imt_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int NW = CW + 2;
	localparam int DW = KEY_WIDTH + VALUE_WIDTH;

	imt_state_t state_q, state_d;

	logic [CW-1:0]          cnt_q, idx_q, lo_q, hi_q, src_q, dst_q, rem_q, pos_q, newcnt_q;
	logic                   pend_s1, down_q, cmd_q;
	logic [KEY_WIDTH-1:0]   b_q, e_q;
	logic [VALUE_WIDTH-1:0] v_q, left_q, right_q, init_q, mapped_q;
	logic                   empty_q, ovf_q;

	logic                   we;
	logic [AW-1:0]          waddr, raddr;
	logic [DW-1:0]          wdata, rdata;
	logic [KEY_WIDTH-1:0]   rd_key;
	logic [VALUE_WIDTH-1:0] rd_val;

	logic          ins_l, ins_r;
	logic [NW-1:0] newcnt, dest, tail;
	logic          accept;

	assign accept = in_valid && in_ready;
	assign rd_key = rdata[DW-1:VALUE_WIDTH];
	assign rd_val = rdata[VALUE_WIDTH-1:0];
	assign ins_l  = v_q != left_q;
	assign ins_r  = right_q != v_q;
	assign dest   = NW'(lo_q) + NW'(ins_l) + NW'(ins_r);
	assign tail   = NW'(cnt_q) - NW'(hi_q);
	assign newcnt = dest + tail;

	imt_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (command == CMD_ASSIGN && !(range_begin < range_end)) begin
						state_d = ST_RESP;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (idx_q == cnt_q && !pend_s1) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				priority if (cmd_q == CMD_LOOKUP) begin
					state_d = ST_RESP;
				end else if (newcnt > NW'(ENTRIES)) begin
					state_d = ST_RESP;
				end else if (tail == '0 || dest == NW'(hi_q)) begin
					state_d = ST_INS_L;
				end else begin
					state_d = ST_MOVE_RD;
				end
			end
			ST_MOVE_RD: state_d = ST_MOVE_WR;
			ST_MOVE_WR: state_d = (rem_q == CW'(1)) ? ST_INS_L : ST_MOVE_RD;
			ST_INS_L:   state_d = ST_INS_R;
			ST_INS_R:   state_d = ST_RESP;
			ST_RESP: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = dst_q[AW-1:0];
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		unique case (state_q)
			ST_MOVE_RD: raddr = src_q[AW-1:0];
			ST_MOVE_WR: we = 1'b1;
			ST_INS_L: begin
				we    = ins_l;
				waddr = pos_q[AW-1:0];
				wdata = {b_q, v_q};
			end
			ST_INS_R: begin
				we    = ins_r;
				waddr = pos_q[AW-1:0];
				wdata = {e_q, right_q};
			end
			default: begin
			end
		endcase
	end

	assign in_ready       = state_q == ST_IDLE;
	assign out_valid      = state_q == ST_RESP;
	assign mapped_value   = mapped_q;
	assign range_empty    = empty_q;
	assign table_overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			init_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				init_q <= cfg_wdata;
			end
			pend_s1 <= (state_q == ST_SCAN) && (idx_q != cnt_q);
			if (state_q == ST_INS_R) begin
				cnt_q <= newcnt_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			if (rd_key < b_q) begin
				lo_q   <= lo_q + CW'(1);
				left_q <= rd_val;
			end
			if (rd_key <= e_q) begin
				hi_q    <= hi_q + CW'(1);
				right_q <= rd_val;
			end
		end
		unique case (state_q)
			ST_IDLE: begin
				idx_q    <= '0;
				lo_q     <= '0;
				hi_q     <= '0;
				left_q   <= init_q;
				right_q  <= init_q;
				cmd_q    <= command;
				b_q      <= (command == CMD_LOOKUP) ? '0 : range_begin;
				e_q      <= (command == CMD_LOOKUP) ? probe_key : range_end;
				v_q      <= new_value;
				mapped_q <= '0;
				ovf_q    <= 1'b0;
				empty_q  <= (command == CMD_ASSIGN) && !(range_begin < range_end);
			end
			ST_SCAN: begin
				if (idx_q != cnt_q) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_DECIDE: begin
				mapped_q <= (cmd_q == CMD_LOOKUP) ? right_q : '0;
				ovf_q    <= (cmd_q == CMD_ASSIGN) && (newcnt > NW'(ENTRIES));
				newcnt_q <= newcnt[CW-1:0];
				pos_q    <= lo_q;
				rem_q    <= tail[CW-1:0];
				down_q   <= dest > NW'(hi_q);
				if (dest > NW'(hi_q)) begin
					src_q <= cnt_q - CW'(1);
					dst_q <= newcnt[CW-1:0] - CW'(1);
				end else begin
					src_q <= hi_q;
					dst_q <= dest[CW-1:0];
				end
			end
			ST_MOVE_WR: begin
				rem_q <= rem_q - CW'(1);
				src_q <= down_q ? src_q - CW'(1) : src_q + CW'(1);
				dst_q <= down_q ? dst_q - CW'(1) : dst_q + CW'(1);
			end
			ST_INS_L: pos_q <= pos_q + CW'(ins_l);
			default: begin
			end
		endcase
	end
endmodule

FILE: sv/imt_checker.sv
// imt_checker: port level checks for interval_map_table_unit, with bind
// depends on interval_map_table_unit ports
module imt_checker #(
	parameter int VALUE_WIDTH = 8
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [VALUE_WIDTH-1:0] mapped_value,
	input logic                   range_empty,
	input logic                   table_overflow
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mapped_value))
		else $error("output word dropped while stalled");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while result pending");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(range_empty && table_overflow))
		else $error("empty and overflow both set");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (range_empty || table_overflow) |-> mapped_value == '0)
		else $error("assign word with nonzero value");
endmodule

bind interval_map_table_unit imt_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_imt_checker (.*);
